// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/pcpfl_pkg.sv =====
package pcpfl_pkg;

    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;
    localparam int CPU_ID_W = 3;

    localparam int DEF_NUM_PAGES = 1024;
    localparam int DEF_NUM_CPUS = 8;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam longint unsigned RESET_BASE = 64'd2147483648;
    localparam longint unsigned RESET_TOP = 64'd2281701376;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    // config register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_TOP = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_PAGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

    // result of the free address check
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] idx;
    } t_chk;

endpackage

// ===== rtl/core/per_cpu_page_free_list_allocator.sv =====
// channel    | direction | handshake                     | payload
// -----------+-----------+-------------------------------+----------------------------------
// request    | in        | i_req_valid / o_req_ready     | command, cpu_id, page_address
// response   | out       | o_rsp_valid / i_rsp_ready     | granted_address, status
// config     | in        | i_cfg_valid / o_cfg_ready     | cfg_index, cfg_data
//
// a free or a failed allocate ends in the exec state, a successful allocate in the pop
// state: the pop reads the head page's link from the link memory (registered read) before
// the new head is known. the next request is taken in the last cycle of the current one.
// reset (synchronous, active low) empties all lists and loads the default region.
// a response waiting on i_rsp_ready stalls the request only when the next result is due.
module per_cpu_page_free_list_allocator
    import pcpfl_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int NUM_CPUS = DEF_NUM_CPUS,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic                i_req_command,
    input  logic [CPU_ID_W-1:0] i_req_cpu_id,
    input  logic [ADDR_W-1:0]   i_req_page_address,

    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [ADDR_W-1:0]   o_rsp_granted_address,
    output logic [STAT_W-1:0]   o_rsp_status,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_data
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(2 * NUM_PAGES);
    localparam int CPUW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int OFF = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] COUNT_MAX = CW'(2 * NUM_PAGES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    function automatic logic [CPUW-1:0] cpu_mod(input logic [CPU_ID_W-1:0] c);
        logic [4:0] v;
        v = {2'b00, c};
        for (int k = 0; k < 8; k++) begin
            if (v >= 5'(NUM_CPUS)) begin
                v = v - 5'(NUM_CPUS);
            end
        end
        return v[CPUW-1:0];
    endfunction

    t_state            r_state;
    t_state            n_state;

    logic              r_cmd;
    logic [CPUW-1:0]   r_cpu;
    logic [ADDR_W-1:0] r_addr;
    logic [CPUW-1:0]   r_sel;
    logic [PW-1:0]     r_pg;

    logic [PW-1:0]     r_head [NUM_CPUS];
    logic [CW-1:0]     r_cnt [NUM_CPUS];

    logic              r_rsp_valid;
    logic [ADDR_W-1:0] r_rsp_addr;
    logic [STAT_W-1:0] r_rsp_status;

    t_chk              w_chk;
    logic [ADDR_W:0]   w_base_up;
    logic [PW-1:0]     w_link;
    logic              w_found;
    logic [CPUW-1:0]   w_sel;
    logic              w_out_free;
    logic              w_done;
    logic              w_accept;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_grant;

    pcpfl_addr_chk #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_addr_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_addr     (r_addr),
        .o_chk      (w_chk),
        .o_base_up  (w_base_up)
    );

    pcpfl_link_ram #(
        .DEPTH(NUM_PAGES),
        .WIDTH(PW),
        .AW   (PW)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_chk.idx[PW-1:0]),
        .i_wr_data(r_head[r_cpu]),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_head[w_sel]),
        .o_rd_data(w_link)
    );

    // round-robin search from the requesting cpu, first non-empty list wins
    always_comb begin
        int id;
        w_found = 1'b0;
        w_sel = r_cpu;
        for (int k = NUM_CPUS - 1; k >= 0; k--) begin
            id = int'(r_cpu) + k;
            if (id >= NUM_CPUS) begin
                id = id - NUM_CPUS;
            end
            if (r_cnt[CPUW'(id)] != '0) begin
                w_found = 1'b1;
                w_sel = CPUW'(id);
            end
        end
    end

    assign w_out_free = !r_rsp_valid || i_rsp_ready;
    assign w_done = w_out_free &&
        (((r_state == S_EXEC) && ((r_cmd == CMD_FREE) || !w_found)) || (r_state == S_POP));
    assign o_req_ready = (r_state == S_IDLE) || w_done;
    assign w_accept = i_req_valid && o_req_ready;

    assign w_wr_en = (r_state == S_EXEC) && (r_cmd == CMD_FREE) && w_chk.ok && w_out_free;
    assign w_rd_en = (r_state == S_EXEC) && (r_cmd == CMD_ALLOC) && w_found;
    assign w_grant = w_base_up[ADDR_W-1:0] + (ADDR_W'(r_pg) << OFF);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_rd_en) begin
                    n_state = S_POP;
                end else if (w_done) begin
                    n_state = w_accept ? S_EXEC : S_IDLE;
                end
            end
            S_POP: begin
                if (w_done) begin
                    n_state = w_accept ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_valid <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_head[c] <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_cmd <= i_req_command;
                r_cpu <= cpu_mod(i_req_cpu_id);
                r_addr <= i_req_page_address;
            end

            if (w_rd_en) begin
                r_sel <= w_sel;
                r_pg <= r_head[w_sel];
            end

            // push on the own list
            if (w_wr_en) begin
                r_head[r_cpu] <= w_chk.idx[PW-1:0];
                if (r_cnt[r_cpu] < COUNT_MAX) begin
                    r_cnt[r_cpu] <= r_cnt[r_cpu] + CW'(1);
                end
            end

            // pop: new head is the link read in the exec state
            if ((r_state == S_POP) && w_out_free) begin
                r_head[r_sel] <= w_link;
                r_cnt[r_sel] <= r_cnt[r_sel] - CW'(1);
            end

            if (w_done) begin
                r_rsp_valid <= 1'b1;
                if (r_state == S_POP) begin
                    r_rsp_addr <= w_grant;
                    r_rsp_status <= ST_OK;
                end else if (r_cmd == CMD_FREE) begin
                    r_rsp_addr <= '0;
                    r_rsp_status <= w_chk.ok ? ST_OK : ST_BAD_FREE;
                end else begin
                    r_rsp_addr <= '0;
                    r_rsp_status <= ST_NO_PAGE;
                end
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp_granted_address = r_rsp_addr;
    assign o_rsp_status = r_rsp_status;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/core/pcpfl_link_ram.sv =====
module pcpfl_link_ram
    import pcpfl_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_PAGES,
    parameter int WIDTH = $clog2(DEF_NUM_PAGES),
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/pcpfl_addr_chk.sv =====
module pcpfl_addr_chk
    import pcpfl_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0] i_addr,
    output t_chk              o_chk,
    output logic [ADDR_W:0]   o_base_up
);

    localparam int OFF = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W:0] PAGE_MASK = {{(ADDR_W + 1 - OFF){1'b1}}, {OFF{1'b0}}};
    localparam longint unsigned BASE_RST_L =
        ((RESET_BASE + longint'(PAGE_BYTES) - 64'd1) / longint'(PAGE_BYTES))
        * longint'(PAGE_BYTES);

    // base is kept already rounded up to a page, with a carry bit
    logic [ADDR_W:0]   r_base_up;
    logic [ADDR_W-1:0] r_top;
    logic [ADDR_W:0]   n_base_up;
    logic [ADDR_W:0]   w_diff;
    logic [ADDR_W:0]   w_idx_full;
    logic              w_aligned;
    logic              w_ge;
    logic              w_lt;
    logic              w_in_range;

    assign n_base_up = ({1'b0, i_cfg_data} + (ADDR_W + 1)'(PAGE_BYTES - 1)) & PAGE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_up <= (ADDR_W + 1)'(BASE_RST_L);
            r_top <= ADDR_W'(RESET_TOP);
        end else if (i_cfg_wr) begin
            if (i_cfg_index == CFG_BASE) begin
                r_base_up <= n_base_up;
            end else begin
                r_top <= i_cfg_data;
            end
        end
    end

    assign w_aligned = (i_addr[OFF-1:0] == '0);
    assign w_ge = ({1'b0, i_addr} >= r_base_up);
    assign w_lt = (i_addr < r_top);
    assign w_diff = {1'b0, i_addr} - r_base_up;
    assign w_idx_full = w_diff >> OFF;
    assign w_in_range = (w_idx_full < (ADDR_W + 1)'(NUM_PAGES));

    assign o_chk.ok = w_aligned && w_ge && w_lt && w_in_range;
    assign o_chk.idx = w_idx_full[ADDR_W-1:0];
    assign o_base_up = r_base_up;

endmodule

// ===== rtl/core/pcpfl_checker.sv =====
`include "assert_macros.svh"

module pcpfl_checker
    import pcpfl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_rsp_valid,
    input logic              i_rsp_ready,
    input logic [ADDR_W-1:0] o_rsp_granted_address,
    input logic [STAT_W-1:0] o_rsp_status
);

    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp_granted_address) && $stable(o_rsp_status)), "response changed while stalled")

    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (o_rsp_valid && (o_rsp_status != ST_OK)) |-> (o_rsp_granted_address == '0), "failed response carries an address")

    `ASSERT_CLK(a_rst_quiet, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_rsp_valid, "response pending right after reset")

    `ASSERT_NEVER(a_stat_code, i_clk, i_rst_n, o_rsp_valid && (o_rsp_status != ST_OK) && (o_rsp_status != ST_NO_PAGE) && (o_rsp_status != ST_BAD_FREE), "unknown status code")

endmodule

bind per_cpu_page_free_list_allocator pcpfl_checker u_pcpfl_checker (.*);

// ===== tb/per_cpu_page_free_list_allocator_test.sv =====
`timescale 1ns / 100ps

import pcpfl_pkg::*;

typedef struct packed {
    logic [ADDR_W-1:0] granted;
    logic [STAT_W-1:0] status;
} t_page_grant;

class page_pool_scoreboard;
    localparam int POOL_PAGES = DEF_NUM_PAGES;
    localparam int CPUS = DEF_NUM_CPUS;
    localparam longint unsigned PAGE_SZ = DEF_PAGE_BYTES;
    localparam int IDX_W = $clog2(POOL_PAGES);
    localparam int DEPTH_MAX = 2 * POOL_PAGES - 1;

    logic [IDX_W-1:0]  next_page [POOL_PAGES];
    bit                link_written [POOL_PAGES];
    logic [IDX_W-1:0]  top_page [CPUS];
    logic [IDX_W:0]    depth [CPUS];
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] top_reg;

    t_page_grant       pending_grants [$];
    logic [ADDR_W-1:0] handed_out [$];

    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_grants;
    int unsigned n_empty;
    int unsigned n_frees;
    int unsigned n_bad_frees;

    function new();
        base_reg = RESET_BASE[ADDR_W-1:0];
        top_reg = RESET_TOP[ADDR_W-1:0];
        foreach (next_page[i]) begin
            next_page[i] = '0;
            link_written[i] = 1'b0;
        end
        foreach (top_page[i]) begin
            top_page[i] = '0;
            depth[i] = '0;
        end
    endfunction

    // managed pages begin at the base rounded up, done wide so it may pass 2^32
    function longint unsigned first_page();
        longint unsigned b;
        longint unsigned r;
        b = 64'(base_reg);
        r = b % PAGE_SZ;
        return (r != 0) ? b + (PAGE_SZ - r) : b;
    endfunction

    function int unsigned usable_pages();
        longint unsigned b;
        longint unsigned span;
        b = first_page();
        if (b >= 64'(top_reg))
            return 0;
        span = (64'(top_reg) - b + PAGE_SZ - 1) / PAGE_SZ;
        return (span > POOL_PAGES) ? POOL_PAGES : int'(span);
    endfunction

    function logic [ADDR_W-1:0] some_usable_page();
        longint unsigned k;
        k = 64'($urandom_range(0, usable_pages() - 1));
        return ADDR_W'(first_page() + k * PAGE_SZ);
    endfunction

    // an allocate must never follow a link that was never stored
    function bit pop_is_safe(logic [CPU_ID_W-1:0] cpu);
        int id;
        id = int'(cpu) % CPUS;
        for (int n = 0; n < CPUS; n++) begin
            if (depth[id] != 0)
                return link_written[top_page[id]];
            id = (id + 1) % CPUS;
        end
        return 1'b1;
    endfunction

    function int unsigned pending();
        return pending_grants.size();
    endfunction

    function void write_register(logic idx, logic [ADDR_W-1:0] data);
        if (idx == CFG_BASE)
            base_reg = data;
        else
            top_reg = data;
    endfunction

    function void note_request(logic cmd, logic [CPU_ID_W-1:0] cpu, logic [ADDR_W-1:0] addr);
        t_page_grant exp;
        longint unsigned b;
        longint unsigned a;
        longint unsigned idx;
        int id;
        int pg;
        b = first_page();
        a = 64'(addr);
        id = int'(cpu) % CPUS;
        exp.granted = '0;
        exp.status = ST_OK;
        n_requests++;
        if (cmd == CMD_FREE) begin
            idx = (a >= b) ? (a - b) / PAGE_SZ : 0;
            if (a % PAGE_SZ != 0 || a < b || a >= 64'(top_reg) || idx >= POOL_PAGES) begin
                exp.status = ST_BAD_FREE;
                n_bad_frees++;
            end else begin
                next_page[idx] = top_page[id];
                link_written[idx] = 1'b1;
                top_page[id] = IDX_W'(idx);
                if (depth[id] < DEPTH_MAX)
                    depth[id]++;
                n_frees++;
            end
        end else begin
            exp.status = ST_NO_PAGE;
            // round-robin search from the requesting cpu, steal from the first non-empty list
            for (int n = 0; n < CPUS; n++) begin
                if (exp.status == ST_NO_PAGE && depth[id] != 0) begin
                    pg = int'(top_page[id]);
                    top_page[id] = next_page[pg];
                    depth[id]--;
                    exp.granted = ADDR_W'(b + pg * PAGE_SZ);
                    exp.status = ST_OK;
                    handed_out.push_back(exp.granted);
                end
                id = (id + 1) % CPUS;
            end
            if (exp.status == ST_OK)
                n_grants++;
            else
                n_empty++;
        end
        pending_grants.push_back(exp);
    endfunction

    function void check_response(logic [ADDR_W-1:0] granted, logic [STAT_W-1:0] status);
        t_page_grant exp;
        if (pending_grants.size() == 0) begin
            $error("response with no request outstanding: granted_address %h status %0d",
                   granted, status);
            errors++;
            return;
        end
        exp = pending_grants.pop_front();
        if (granted !== exp.granted) begin
            $error("granted_address: expected %h, got %h", exp.granted, granted);
            errors++;
        end
        if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
        end
    endfunction
endclass

module per_cpu_page_free_list_allocator_test;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_req_valid = 1'b0;
    logic                o_req_ready;
    logic                i_req_command = CMD_ALLOC;
    logic [CPU_ID_W-1:0] i_req_cpu_id = '0;
    logic [ADDR_W-1:0]   i_req_page_address = '0;
    logic                o_rsp_valid;
    logic                i_rsp_ready = 1'b0;
    logic [ADDR_W-1:0]   o_rsp_granted_address;
    logic [STAT_W-1:0]   o_rsp_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]   i_cfg_data = '0;

    page_pool_scoreboard sb = new();

    int burst_left = 0;
    int rsp_style = 0;
    int rsp_style_left = 0;
    int region_settings = 1;

    per_cpu_page_free_list_allocator uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (i_req_valid && o_req_ready)
                sb.note_request(i_req_command, i_req_cpu_id, i_req_page_address);
            if (o_rsp_valid && i_rsp_ready)
                sb.check_response(o_rsp_granted_address, o_rsp_status);
        end
    end

    // receiver switches between always ready, light stalls and heavy stalls
    always @(negedge i_clk) begin
        if (rsp_style_left == 0) begin
            rsp_style <= $urandom_range(0, 2);
            rsp_style_left <= $urandom_range(20, 80);
        end else begin
            rsp_style_left <= rsp_style_left - 1;
        end
        case (rsp_style)
            0: i_rsp_ready <= 1'b1;
            1: i_rsp_ready <= ($urandom_range(0, 2) != 0);
            default: i_rsp_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_request(input logic cmd, input logic [CPU_ID_W-1:0] cpu,
                                input logic [ADDR_W-1:0] addr);
        if (burst_left == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_req_valid <= 1'b1;
        i_req_command <= cmd;
        i_req_cpu_id <= cpu;
        i_req_page_address <= addr;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_req_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_region(input logic [ADDR_W-1:0] new_base,
                              input logic [ADDR_W-1:0] new_top);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data <= new_base;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_TOP;
        i_cfg_data <= new_top;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        region_settings++;
    endtask

    task automatic random_item(input int alloc_pct);
        int pick;
        int k;
        logic [CPU_ID_W-1:0] cpu;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        cpu = CPU_ID_W'($urandom_range(0, 7));
        addr = $urandom;
        if (pick < alloc_pct && sb.pop_is_safe(cpu)) begin
            send_request(CMD_ALLOC, cpu, addr);
        end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 10 &&
                     sb.handed_out.size() != 0) begin
            // give back a page that was handed out earlier
            k = $urandom_range(0, sb.handed_out.size() - 1);
            addr = sb.handed_out[k];
            sb.handed_out.delete(k);
            send_request(CMD_FREE, cpu, addr);
        end else if (pick < 90 && sb.usable_pages() != 0) begin
            send_request(CMD_FREE, cpu, sb.some_usable_page());
        end else begin
            case ($urandom_range(0, 3))
                0: ;
                1: if (sb.usable_pages() != 0)
                    addr = sb.some_usable_page() | ADDR_W'($urandom_range(1, 4095));
                2: addr = sb.top_reg;
                default: addr = ADDR_W'(sb.first_page()) - ADDR_W'(DEF_PAGE_BYTES);
            endcase
            send_request(CMD_FREE, cpu, addr);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] new_base,
                             input logic [ADDR_W-1:0] new_top,
                             input int count, input int alloc_pct);
        set_region(new_base, new_top);
        repeat (count) random_item(alloc_pct);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default region: first page 8000_0000, 1024 pages
        send_request(CMD_ALLOC, 3'd0, 32'h0000_0000);
        send_request(CMD_FREE, 3'd0, 32'h8000_0000);
        send_request(CMD_FREE, 3'd7, 32'h803F_F000);
        send_request(CMD_FREE, 3'd3, 32'h8040_0000);
        send_request(CMD_FREE, 3'd1, 32'h8000_0800);
        send_request(CMD_FREE, 3'd2, 32'h7FFF_F000);
        send_request(CMD_FREE, 3'd4, 32'h8800_0000);
        send_request(CMD_FREE, 3'd5, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 3'd6, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 3'd7, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd5, 32'h0000_0000);
        // same page freed twice, both copies come back out
        send_request(CMD_FREE, 3'd2, 32'h8000_1000);
        send_request(CMD_FREE, 3'd2, 32'h8000_1000);
        send_request(CMD_ALLOC, 3'd2, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd2, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd3, 32'h0000_0000);
        send_request(CMD_FREE, 3'd1, 32'h8000_2000);
        send_request(CMD_FREE, 3'd1, 32'h8000_3000);
        send_request(CMD_ALLOC, 3'd1, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd6, 32'h0000_0000);
        wait_idle();

        repeat (40) random_item(40);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 80, 35);
        // unaligned base, 250 pages; pages still queued now map to the new base
        run_phase(32'h1234_5678, 32'h1244_0000, 80, 55);
        // base rounds past 32 bits: every free is rejected, grants wrap
        run_phase(32'hFFFF_F001, 32'hFFFF_FFFF, 50, 60);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 40, 45);
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, 30, 70);
        run_phase(32'h0000_0000, 32'h0004_0000, 70, 50);

        // push one page many times onto one list, the self link hands it out again each pop
        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        repeat (12) send_request(CMD_FREE, 3'd4, 32'h0000_5000);
        repeat (12) send_request(CMD_ALLOC, 3'd4, 32'h0000_0000);
        repeat (30) random_item(70);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected responses never arrived", sb.pending());
            sb.errors++;
        end
        $display("covered %0d requests over %0d region settings, including repeated double frees",
                 sb.n_requests, region_settings);
        $display("%0d grants, %0d empty-pool replies, %0d frees taken, %0d frees rejected",
                 sb.n_grants, sb.n_empty, sb.n_frees, sb.n_bad_frees);
        if (sb.errors == 0)
            $display("per_cpu_page_free_list_allocator verification clean");
        else
            $display("per_cpu_page_free_list_allocator verification failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("per_cpu_page_free_list_allocator verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pcpfl_pkg.sv
rtl/core/pcpfl_link_ram.sv
rtl/core/pcpfl_addr_chk.sv
rtl/core/per_cpu_page_free_list_allocator.sv
rtl/core/pcpfl_checker.sv
tb/per_cpu_page_free_list_allocator_test.sv
